// File: design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared command codes and control bundles of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

   // Bookkeeping operation applied to the valid and age tables.
   typedef struct packed {
      logic touch;
      logic fill;
      logic remove;
   } upd_type;

   // Outcome of one scan over the store.
   typedef struct packed {
      logic hit;
   } match_status_type;

endpackage

// File: design/lkvc_store.sv
// ----------------------------------------------------------------------------
// lkvc_store
// Key and value memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lkvc_store #(
   parameter int CAPACITY = 8,
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [IDX_W-1:0]                wr_addr,
   input  logic [lkvc_pkg::KEY_W-1:0]      wr_key,
   input  logic [lkvc_pkg::VALUE_W-1:0]    wr_value,
   input  logic [IDX_W-1:0]                rd_addr,
   output logic [lkvc_pkg::KEY_W-1:0]      rd_key,
   output logic [lkvc_pkg::VALUE_W-1:0]    rd_value
);
   import lkvc_pkg::*;

   logic [KEY_W-1:0]   key_mem   [CAPACITY];
   logic [VALUE_W-1:0] value_mem [CAPACITY];
   logic [KEY_W-1:0]   rd_key_ff;
   logic [VALUE_W-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         value_mem[wr_addr] <= wr_value;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

// File: design/lkvc_match.sv
// ----------------------------------------------------------------------------
// lkvc_match
// Shared compare unit: examines one entry per cycle and keeps the hit, the
// first free slot and the least recent slot seen so far.
// ----------------------------------------------------------------------------
module lkvc_match #(
   parameter int CAPACITY = 8,
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                            clock,
   input  logic                            clear,
   input  logic                            cmp_en,
   input  logic [IDX_W-1:0]                cmp_idx,
   input  logic [lkvc_pkg::KEY_W-1:0]      cmp_key,
   input  logic [lkvc_pkg::VALUE_W-1:0]    cmp_value,
   input  logic                            cmp_entry_valid,
   input  logic [IDX_W-1:0]                cmp_rank,
   input  logic [lkvc_pkg::KEY_W-1:0]      req_key,
   output lkvc_pkg::match_status_type      status,
   output logic [IDX_W-1:0]                hit_slot,
   output logic [IDX_W-1:0]                hit_rank,
   output logic [lkvc_pkg::VALUE_W-1:0]    hit_value,
   output logic [IDX_W-1:0]                fill_slot
);
   import lkvc_pkg::*;

   localparam logic [IDX_W-1:0] OLDEST = IDX_W'(CAPACITY - 1);

   logic               hit_ff,       hit_in;
   logic [IDX_W-1:0]   hit_slot_ff,  hit_slot_in;
   logic [IDX_W-1:0]   hit_rank_ff,  hit_rank_in;
   logic [VALUE_W-1:0] hit_value_ff, hit_value_in;
   logic               free_ff,      free_in;
   logic [IDX_W-1:0]   free_slot_ff, free_slot_in;
   logic [IDX_W-1:0]   lru_slot_ff,  lru_slot_in;

   always_comb begin
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_rank_in  = hit_rank_ff;
      hit_value_in = hit_value_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      lru_slot_in  = lru_slot_ff;
      if (clear) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (cmp_en) begin
         if (cmp_entry_valid && (cmp_key == req_key) && !hit_ff) begin
            hit_in       = 1'b1;
            hit_slot_in  = cmp_idx;
            hit_rank_in  = cmp_rank;
            hit_value_in = cmp_value;
         end
         if (!cmp_entry_valid && !free_ff) begin
            free_in      = 1'b1;
            free_slot_in = cmp_idx;
         end
         if (cmp_entry_valid && (cmp_rank == OLDEST)) begin
            lru_slot_in = cmp_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      hit_rank_ff  <= hit_rank_in;
      hit_value_ff <= hit_value_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      lru_slot_ff  <= lru_slot_in;
   end

   assign status.hit  = hit_ff;
   assign hit_slot    = hit_slot_ff;
   assign hit_rank    = hit_rank_ff;
   assign hit_value   = hit_value_ff;
   // When the store is full the new key replaces the least recent entry.
   assign fill_slot   = free_ff ? free_slot_ff : lru_slot_ff;

endmodule

// File: design/lkvc_age_table.sv
// ----------------------------------------------------------------------------
// lkvc_age_table
// Valid bits and age ranks of all entries, updated together.
// ----------------------------------------------------------------------------
module lkvc_age_table #(
   parameter int CAPACITY = 8,
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  lkvc_pkg::upd_type   upd,
   input  logic [IDX_W-1:0]    upd_slot,
   input  logic [IDX_W-1:0]    upd_rank,
   input  logic [IDX_W-1:0]    rd_idx,
   output logic                rd_valid,
   output logic [IDX_W-1:0]    rd_rank
);
   import lkvc_pkg::*;

   logic             valid_ff [CAPACITY];
   logic             valid_in [CAPACITY];
   logic [IDX_W-1:0] rank_ff  [CAPACITY];
   logic [IDX_W-1:0] rank_in  [CAPACITY];

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (upd.touch) begin
            if (IDX_W'(i) == upd_slot) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < upd_rank)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end else if (upd.fill) begin
            if (IDX_W'(i) == upd_slot) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end else if (upd.remove) begin
            if (IDX_W'(i) == upd_slot) begin
               valid_in[i] = 1'b0;
               rank_in[i]  = '0;
            end else if (valid_ff[i] && (rank_ff[i] > upd_rank)) begin
               rank_in[i] = rank_ff[i] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end else begin
            valid_ff[i] <= valid_in[i];
            rank_ff[i]  <= rank_in[i];
         end
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_rank  = rank_ff[rd_idx];

endmodule

// File: design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store kept in least-recently-used order.
// ----------------------------------------------------------------------------
// A request is taken when the block is idle and then occupies it until its
// result is loaded. The key scan reads one entry of the key/value memory per
// cycle and feeds it to a single compare unit. After the scan come a drain
// state for the memory read, an update state for the valid and age tables
// and a done state, which waits until the result register can take the
// new result and then loads it. The result sits in its
// own register, so the next request is accepted while the previous result
// still waits to be taken. Reset empties the store at once through the valid
// bits; no clearing pass is needed. A lookup hit returns the stored value and
// makes the entry most recent; an insert of a present key only refreshes its
// age; an insert of a new key evicts the least recent entry when the store is
// full; an erase removes the key. Found always tells whether the key was
// present before the request, and value_out is zero except on a lookup hit.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int CAPACITY = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [lkvc_pkg::CMD_W-1:0]              req_command,
   input  logic signed [lkvc_pkg::KEY_W-1:0]       req_key,
   input  logic signed [lkvc_pkg::VALUE_W-1:0]     req_value_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_found,
   output logic signed [lkvc_pkg::VALUE_W-1:0]     rsp_value_out
);
   import lkvc_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DRAIN  = 5'b00100,
      S_UPDATE = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               cmp_valid_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic [CMD_W-1:0]   cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   logic               req_fire;
   logic               rsp_load;

   logic [KEY_W-1:0]   rd_key;
   logic [VALUE_W-1:0] rd_value;
   logic               rd_entry_valid;
   logic [IDX_W-1:0]   rd_rank;

   match_status_type   status;
   logic [IDX_W-1:0]   hit_slot;
   logic [IDX_W-1:0]   hit_rank;
   logic [VALUE_W-1:0] hit_value;
   logic [IDX_W-1:0]   fill_slot;

   upd_type            upd;
   logic [IDX_W-1:0]   upd_slot;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer: scan every entry, settle, apply the table update, report.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (req_fire) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The table update depends only on the command and whether the key hit.
   always_comb begin
      upd      = '0;
      upd_slot = hit_slot;
      if (state_ff == S_UPDATE) begin
         case (cmd_ff)
            CMD_LOOKUP: begin
               upd.touch = status.hit;
            end
            CMD_INSERT: begin
               upd.touch = status.hit;
               upd.fill  = !status.hit;
               if (!status.hit) begin
                  upd_slot = fill_slot;
               end
            end
            CMD_ERASE: begin
               upd.remove = status.hit;
            end
            default: begin
               // The unused command code only reports whether the key is held.
               upd = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cmp_valid_ff <= (state_ff == S_SCAN);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= idx_ff;
      if (req_fire) begin
         cmd_ff   <= req_command;
         key_ff   <= req_key;
         value_ff <= req_value_in;
      end
      if (rsp_load) begin
         rsp_found_ff <= status.hit;
         rsp_value_ff <= ((cmd_ff == CMD_LOOKUP) && status.hit) ? hit_value : '0;
      end
   end

   lkvc_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock    (clock),
      .wr_en    (upd.fill),
      .wr_addr  (fill_slot),
      .wr_key   (key_ff),
      .wr_value (value_ff),
      .rd_addr  (idx_ff),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   lkvc_age_table #(
      .CAPACITY (CAPACITY)
   ) u_age_table (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .upd_slot (upd_slot),
      .upd_rank (hit_rank),
      .rd_idx   (cmp_idx_ff),
      .rd_valid (rd_entry_valid),
      .rd_rank  (rd_rank)
   );

   lkvc_match #(
      .CAPACITY (CAPACITY)
   ) u_match (
      .clock           (clock),
      .clear           (req_fire),
      .cmp_en          (cmp_valid_ff),
      .cmp_idx         (cmp_idx_ff),
      .cmp_key         (rd_key),
      .cmp_value       (rd_value),
      .cmp_entry_valid (rd_entry_valid),
      .cmp_rank        (rd_rank),
      .req_key         (key_ff),
      .status          (status),
      .hit_slot        (hit_slot),
      .hit_rank        (hit_rank),
      .hit_value       (hit_value),
      .fill_slot       (fill_slot)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_value_out = rsp_value_ff;

`ifndef SYNTH
   // The last entry is compared while the scan drains.
   a_drain_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> (cmp_valid_ff && (cmp_idx_ff == LAST_IDX)))
      else $error("scan did not end on the last entry");

   // A new entry is only written when the key was not already held.
   a_fill_miss: assert property (@(posedge clock) disable iff (reset)
      upd.fill |-> (!status.hit && (cmd_ff == CMD_INSERT)))
      else $error("fill issued for a key that hit");

   // The update state, where the tables change, is followed by the done state.
   a_update_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |=> (state_ff == S_DONE))
      else $error("update state did not move on to the result");

   // No request is taken while the sequencer is busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while busy");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU key/value cache.
// ----------------------------------------------------------------------------
// Requests go in through a valid/ready channel. Each accepted request is run
// through a behavioral copy of the store, which keeps its own valid bits,
// keys, values and age ranks. The expected found flag and value go into a
// queue in request order. Every accepted response is compared with the
// oldest entry of that queue.
//
// Stimulus runs in two parts. A short directed table comes first: the empty
// store, extreme keys and values, every command including the unused code,
// a re-insert of a present key, a double erase, and an eviction after a
// touch. After that come random requests. Their keys are drawn mostly from a
// small pool that changes now and then, so that hits, refreshes and
// evictions are common. Both sides idle at random. The sink also holds off
// once for a long stretch, so that the cache backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
   import lkvc_pkg::*;

   localparam int CAPACITY        = 8;
   localparam int DIRECTED_COUNT  = 25;
   localparam int RANDOM_ITEMS    = 1680;
   localparam int POOL_DEPTH      = 20;
   localparam int HOLD_OFF_CYCLES = 100;
   localparam int STALL_LIMIT     = 2000;

   // The block compares the key for this code but changes nothing.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] value_out;
   } cache_result_type;

   // One row of the directed table. Where known is set, the result is written
   // out in the row. Otherwise the behavioral store supplies it.
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               known;
      logic               found;
      logic [VALUE_W-1:0] value_out;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid    = 1'b0;
   logic               req_ready;
   logic [CMD_W-1:0]   req_command  = CMD_LOOKUP;
   logic [KEY_W-1:0]   req_key      = '0;
   logic [VALUE_W-1:0] req_value_in = '0;
   logic               rsp_valid;
   logic               rsp_ready    = 1'b0;
   logic               rsp_found;
   logic [VALUE_W-1:0] rsp_value_out;

   // A written-out result travels with the request it belongs to.
   logic               known_result = 1'b0;
   logic               known_found  = 1'b0;
   logic [VALUE_W-1:0] known_value  = '0;

   // Behavioral copy of the store.
   bit                 slot_valid [CAPACITY];
   logic [KEY_W-1:0]   slot_key   [CAPACITY];
   logic [VALUE_W-1:0] slot_value [CAPACITY];
   int unsigned        slot_rank  [CAPACITY];

   cache_result_type expected_results [$];
   int            requests_taken   = 0;
   int            responses_seen   = 0;
   int            mismatch_count   = 0;
   int            idle_cycles      = 0;
   int            burst_left       = 0;
   bit            hold_off_request = 1'b0;

   logic [KEY_W-1:0] key_pool [POOL_DEPTH];
   int               pool_size = 4;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // Empty store: every command misses.
      '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{CMD_ERASE,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{CMD_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      // Most negative key with the largest value, then read it back.
      '{CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
      '{CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
      // Inserting a present key refreshes it but keeps the stored value.
      '{CMD_INSERT, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
      // The unused code reports a hit with a zero value.
      '{CMD_UNUSED, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
      '{CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
      // The first erase removes the key and the second one misses.
      '{CMD_ERASE,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{CMD_ERASE,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      // A key one bit away from the just-erased key must miss as well.
      '{CMD_LOOKUP, 32'h7FFF_FFFE, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      // These five fill the store.
      '{CMD_INSERT, 32'h0000_0001, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0000_0000},
      '{CMD_INSERT, 32'h0000_0002, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0000_0000},
      '{CMD_INSERT, 32'h0000_0003, 32'h0F0F_0F0F, 1'b0, 1'b0, 32'h0000_0000},
      '{CMD_INSERT, 32'h0000_0004, 32'hF0F0_F0F0, 1'b0, 1'b0, 32'h0000_0000},
      '{CMD_INSERT, 32'h0000_0005, 32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000},
      // Touch the oldest entry, so that the next new key evicts another one.
      '{CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{CMD_INSERT, 32'h0000_0006, 32'h8765_4321, 1'b0, 1'b0, 32'h0000_0000},
      '{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{CMD_INSERT, 32'h0000_0007, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0000_0000}
   };

   lru_key_value_cache #(
      .CAPACITY      (CAPACITY)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_key       (req_key),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_found     (rsp_found),
      .rsp_value_out (rsp_value_out)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Behavioral store
   // ---------------------------------------------------------------------

   // Make a slot the most recent. Younger valid entries age by one.
   function automatic void mark_recent(input int s);
      int unsigned r;
      r = slot_rank[s];
      for (int i = 0; i < CAPACITY; i++)
         if (slot_valid[i] && slot_rank[i] < r)
            slot_rank[i]++;
      slot_rank[s] = 0;
   endfunction

   // Free a slot. Older valid entries move up by one.
   function automatic void drop_slot(input int s);
      int unsigned r;
      r = slot_rank[s];
      slot_valid[s] = 1'b0;
      slot_rank[s]  = 0;
      for (int i = 0; i < CAPACITY; i++)
         if (slot_valid[i] && slot_rank[i] > r)
            slot_rank[i]--;
   endfunction

   function automatic cache_result_type cache_apply(input logic [CMD_W-1:0] cmd,
                                                    input logic [KEY_W-1:0] k,
                                                    input logic [VALUE_W-1:0] v);
      cache_result_type res;
      int            hit_slot;
      int            free_slot;
      int            held;
      res      = '0;
      hit_slot = -1;
      held     = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (slot_valid[i])
            held++;
         if (slot_valid[i] && slot_key[i] == k && hit_slot < 0)
            hit_slot = i;
      end
      res.found = (hit_slot >= 0);
      case (cmd)
         CMD_LOOKUP: begin
            if (hit_slot >= 0) begin
               res.value_out = slot_value[hit_slot];
               mark_recent(hit_slot);
            end
         end
         CMD_INSERT: begin
            if (hit_slot >= 0) begin
               mark_recent(hit_slot);
            end else begin
               if (held >= CAPACITY) begin
                  for (int i = 0; i < CAPACITY; i++)
                     if (slot_valid[i] && slot_rank[i] == CAPACITY - 1) begin
                        drop_slot(i);
                        break;
                     end
               end
               free_slot = -1;
               for (int i = 0; i < CAPACITY; i++)
                  if (!slot_valid[i] && free_slot < 0)
                     free_slot = i;
               for (int i = 0; i < CAPACITY; i++)
                  if (slot_valid[i])
                     slot_rank[i]++;
               slot_valid[free_slot] = 1'b1;
               slot_key[free_slot]   = k;
               slot_value[free_slot] = v;
               slot_rank[free_slot]  = 0;
            end
         end
         CMD_ERASE: begin
            if (hit_slot >= 0)
               drop_slot(hit_slot);
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on response %0d: %s is %h, expected %h",
               responses_seen, what, got, want);
      mismatch_count++;
   endtask

   // Both channels are sampled at the edge, before that edge's updates land.
   always @(posedge clock) begin : monitor
      cache_result_type predicted;
      cache_result_type wanted;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = cache_apply(req_command, req_key, req_value_in);
            if (known_result) begin
               predicted.found     = known_found;
               predicted.value_out = known_value;
            end
            expected_results.push_back(predicted);
            requests_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("unrequested response found", 32'(rsp_found), 32'd0);
            end else begin
               wanted = expected_results.pop_front();
               if (rsp_found !== wanted.found)
                  report_mismatch("found", 32'(rsp_found), 32'(wanted.found));
               if (rsp_value_out !== wanted.value_out)
                  report_mismatch("value_out", rsp_value_out, wanted.value_out);
            end
         end
      end
   end

   // Ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no request or response moved for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Response sink: random stalls, long runs without stalls, and one long
   // hold-off when the request side asks for it.
   // ---------------------------------------------------------------------
   initial begin : response_sink
      int r;
      int span;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               span = $urandom_range(1, 8);
               rsp_ready <= 1'b1;
            end else if (r < 80) begin
               span = $urandom_range(1, 3);
               rsp_ready <= 1'b0;
            end else if (r < 93) begin
               span = $urandom_range(8, 30);
               rsp_ready <= 1'b0;
            end else begin
               span = $urandom_range(40, 150);
               rsp_ready <= 1'b1;
            end
            repeat (span - 1) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Called at a rising edge. Returns at the edge that accepts the request.
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [KEY_W-1:0] k,
                               input logic [VALUE_W-1:0] v,
                               input logic known, input logic kf,
                               input logic [VALUE_W-1:0] kv);
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_key      <= k;
      req_value_in <= v;
      known_result <= known;
      known_found  <= kf;
      known_value  <= kv;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Holds requests back until every response has come.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (responses_seen != requests_taken)
         @(posedge clock);
   endtask

   // Mostly back-to-back or short gaps, now and then a long pause or a burst.
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 80)
         return $urandom_range(1, 3);
      if (r < 94)
         return $urandom_range(4, 12);
      if (r < 97) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(20, 60);
   endfunction

   // New working set of keys. Some keys carry over, and some differ from
   // their neighbor in one bit only.
   function automatic void refresh_pool();
      int r;
      pool_size = $urandom_range(3, POOL_DEPTH);
      for (int i = 0; i < POOL_DEPTH; i++) begin
         r = $urandom_range(0, 3);
         if (i > 0 && r == 0)
            key_pool[i] = key_pool[i - 1] ^ (32'd1 << $urandom_range(0, 31));
         else if (r != 1)
            key_pool[i] = $urandom();
      end
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      if (r < 88)
         return key_pool[$urandom_range(0, pool_size - 1)];
      return $urandom();
   endfunction

   function automatic logic [CMD_W-1:0] pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return CMD_LOOKUP;
      if (r < 72)
         return CMD_INSERT;
      if (r < 93)
         return CMD_ERASE;
      return CMD_UNUSED;
   endfunction

   initial begin : stimulus
      logic [VALUE_W-1:0] v;
      for (int i = 0; i < CAPACITY; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_rank[i]  = 0;
      end
      for (int i = 0; i < POOL_DEPTH; i++)
         key_pool[i] = $urandom();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIRECTED_COUNT; n++) begin
         send_request(directed_rows[n].cmd, directed_rows[n].key,
                      directed_rows[n].value, directed_rows[n].known,
                      directed_rows[n].found, directed_rows[n].value_out);
         idle_for(pick_gap());
      end
      wait_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 200 == 0)
            refresh_pool();
         // Long sink hold-off while requests keep coming back-to-back.
         if (n == 500) begin
            hold_off_request = 1'b1;
            burst_left       = 40;
         end
         // The request side pauses until the cache has fully drained.
         if (n == 1100)
            wait_drained();
         v = ($urandom_range(0, 9) == 0)
                ? ({1'($urandom_range(0, 1)), {31{1'b1}}} ^ 32'h7FFF_FFFF)
                : 32'($urandom());
         send_request(pick_command(), pick_key(), v, 1'b0, 1'b0, '0);
         idle_for(pick_gap());
      end

      wait_drained();
      repeat (CAPACITY + 8) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
